@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ufb_pkg.sv @@
`timescale 1ns / 1ps
package ufb_pkg;

	// Field widths
	localparam int unsigned LEN_W   = 11;
	localparam int unsigned CFG_W   = 48;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned HIDX_W  = 6;
	localparam int unsigned SUM_W   = 20;

	// Header layout
	localparam logic [HIDX_W-1:0] HDR_BYTES = 6'd42;
	localparam logic [11:0] HDR_BYTES_12   = 12'd42;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_VER_IHL     = 8'h45;
	localparam logic [7:0]  IP_TTL         = 8'd64;
	localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
	localparam logic [15:0] IP_LEN_BASE    = 16'd28;
	localparam logic [15:0] UDP_LEN_BASE   = 16'd8;
	localparam logic [15:0] CK_FIXED       = 16'h4500 + 16'h4011;

	// Queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_SRC_MAC  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_DST_MAC  = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_SRC_IP   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_DST_IP   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_SRC_UDP  = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_DST_UDP  = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_IP_IDENT = 3'd6;

	typedef struct packed {
		logic [7:0]       payload_byte;
		logic [LEN_W-1:0] payload_len;
		logic             payload_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
		logic       too_long;
	} out_item_t;

	// Classification made by the front
	typedef enum logic [1:0] {
		K_DATA,
		K_START,
		K_ERR
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic             last;
	} q_entry_t;

	typedef enum logic {
		BK_PASS,
		BK_HEADER
	} back_state_t;

	typedef struct packed {
		logic [47:0] src_mac;
		logic [47:0] dst_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_udp;
		logic [15:0] dst_udp;
		logic [15:0] ip_ident;
	} cfg_t;

	// Select one byte of the 42-byte Ethernet/IPv4/UDP header
	function automatic logic [7:0] hdr_byte(
		input logic [HIDX_W-1:0] idx,
		input cfg_t              c,
		input logic [LEN_W-1:0]  len,
		input logic [15:0]       ck
	);
		logic [15:0] ip_len;
		logic [15:0] udp_len;
		logic [7:0]  b;
		ip_len  = 16'(len) + IP_LEN_BASE;
		udp_len = 16'(len) + UDP_LEN_BASE;
		unique case (idx)
			6'd0:  b = c.dst_mac[47:40];
			6'd1:  b = c.dst_mac[39:32];
			6'd2:  b = c.dst_mac[31:24];
			6'd3:  b = c.dst_mac[23:16];
			6'd4:  b = c.dst_mac[15:8];
			6'd5:  b = c.dst_mac[7:0];
			6'd6:  b = c.src_mac[47:40];
			6'd7:  b = c.src_mac[39:32];
			6'd8:  b = c.src_mac[31:24];
			6'd9:  b = c.src_mac[23:16];
			6'd10: b = c.src_mac[15:8];
			6'd11: b = c.src_mac[7:0];
			6'd12: b = ETHERTYPE_IPV4[15:8];
			6'd13: b = ETHERTYPE_IPV4[7:0];
			6'd14: b = IP_VER_IHL;
			6'd16: b = ip_len[15:8];
			6'd17: b = ip_len[7:0];
			6'd18: b = c.ip_ident[15:8];
			6'd19: b = c.ip_ident[7:0];
			6'd22: b = IP_TTL;
			6'd23: b = IP_PROTO_UDP;
			6'd24: b = ck[15:8];
			6'd25: b = ck[7:0];
			6'd26: b = c.src_ip[31:24];
			6'd27: b = c.src_ip[23:16];
			6'd28: b = c.src_ip[15:8];
			6'd29: b = c.src_ip[7:0];
			6'd30: b = c.dst_ip[31:24];
			6'd31: b = c.dst_ip[23:16];
			6'd32: b = c.dst_ip[15:8];
			6'd33: b = c.dst_ip[7:0];
			6'd34: b = c.src_udp[15:8];
			6'd35: b = c.src_udp[7:0];
			6'd36: b = c.dst_udp[15:8];
			6'd37: b = c.dst_udp[7:0];
			6'd38: b = udp_len[15:8];
			6'd39: b = udp_len[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/ufb_front.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ufb_front import ufb_pkg::*; #(
	parameter int unsigned MaxFrameBytes = 1514
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output q_entry_t q_wdata
);

	logic in_payload_q;
	logic dropping_q;
	logic accept;
	logic reject;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Reject an empty payload or one whose frame would be oversize
	assign reject = (in_data.payload_len == '0) ||
		((12'(in_data.payload_len) + HDR_BYTES_12) > 12'(MaxFrameBytes));

	// Classify the transaction for the back end
	always_comb begin
		q_push       = accept && !dropping_q;
		q_wdata.data = in_data.payload_byte;
		q_wdata.len  = in_data.payload_len;
		q_wdata.last = in_data.payload_last;
		if (in_payload_q) begin
			q_wdata.kind = K_DATA;
		end else if (reject) begin
			q_wdata.kind = K_ERR;
		end else begin
			q_wdata.kind = K_START;
		end
	end

	// Track frame and drop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			dropping_q   <= 1'b0;
		end else if (accept) begin
			if (dropping_q) begin
				if (in_data.payload_last) dropping_q <= 1'b0;
			end else if (in_payload_q) begin
				if (in_data.payload_last) in_payload_q <= 1'b0;
			end else if (reject) begin
				dropping_q <= !in_data.payload_last;
			end else begin
				in_payload_q <= !in_data.payload_last;
			end
		end
	end

	`ASSERT_CLK(a_front_exclusive, !(in_payload_q && dropping_q),
		"front is both passing and dropping")
	`ASSERT_NEXT(a_front_drop_ends, accept && dropping_q && in_data.payload_last,
		!dropping_q, "drop did not end on last byte")

endmodule

@@ rtl/ufb_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ufb_queue import ufb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wdata,
	input  logic     pop,
	output logic     full,
	output logic     nonempty,
	output q_entry_t head
);

	q_entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]     count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`ASSERT_CLK(a_q_no_overflow, !(push && full), "push into full queue")
	`ASSERT_CLK(a_q_no_underflow, !(pop && !nonempty), "pop from empty queue")

endmodule

@@ rtl/ufb_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ufb_back import ufb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              q_nonempty,
	input  q_entry_t          q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data
);

	cfg_t              cfg_q;
	logic [SUM_W-1:0]  cfg_sum_q;
	logic [SUM_W-1:0]  tot_q;
	logic [15:0]       ck_q;
	logic [16:0]       fold1;
	logic [15:0]       fold2;
	back_state_t       state_q;
	back_state_t       state_d;
	logic [HIDX_W-1:0] idx_q;
	logic [HIDX_W-1:0] idx_d;
	logic              can_load;
	logic              emit;
	out_item_t         emit_data;
	logic              out_valid_q;
	out_item_t         out_data_q;
	logic              start_hdr;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_mac  <= '0;
			cfg_q.dst_mac  <= '1;
			cfg_q.src_ip   <= '0;
			cfg_q.dst_ip   <= '0;
			cfg_q.src_udp  <= '0;
			cfg_q.dst_udp  <= '0;
			cfg_q.ip_ident <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_SRC_MAC:  cfg_q.src_mac  <= cfg_data;
				CFG_DST_MAC:  cfg_q.dst_mac  <= cfg_data;
				CFG_SRC_IP:   cfg_q.src_ip   <= cfg_data[31:0];
				CFG_DST_IP:   cfg_q.dst_ip   <= cfg_data[31:0];
				CFG_SRC_UDP:  cfg_q.src_udp  <= cfg_data[15:0];
				CFG_DST_UDP:  cfg_q.dst_udp  <= cfg_data[15:0];
				CFG_IP_IDENT: cfg_q.ip_ident <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Keep the length-independent part of the checksum sum current
	always_ff @(posedge clk) begin
		cfg_sum_q <= SUM_W'(CK_FIXED) + SUM_W'(cfg_q.ip_ident) +
			SUM_W'(cfg_q.src_ip[31:16]) + SUM_W'(cfg_q.src_ip[15:0]) +
			SUM_W'(cfg_q.dst_ip[31:16]) + SUM_W'(cfg_q.dst_ip[15:0]);
	end

	assign can_load  = !out_valid_q || !out_stall;
	assign start_hdr = (state_q == BK_PASS) && q_nonempty && (q_head.kind == K_START);

	// Add the length on the first header byte, then fold and invert
	assign fold1 = 17'(tot_q[SUM_W-1:16]) + 17'(tot_q[15:0]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);

	always_ff @(posedge clk) begin
		if (start_hdr && can_load) begin
			tot_q <= cfg_sum_q + SUM_W'(IP_LEN_BASE) + SUM_W'(q_head.len);
		end
		ck_q <= ~fold2;
	end

	// Next state of the header sequencer
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		if (can_load && q_nonempty) begin
			unique case (state_q)
				BK_PASS: begin
					if (q_head.kind == K_START) begin
						state_d = BK_HEADER;
						idx_d   = HIDX_W'(1);
					end
				end
				BK_HEADER: begin
					if (idx_q == HDR_BYTES) begin
						state_d = BK_PASS;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Outputs of the header sequencer
	always_comb begin
		emit      = 1'b0;
		q_pop     = 1'b0;
		emit_data = '0;
		if (can_load && q_nonempty) begin
			emit = 1'b1;
			unique case (state_q)
				BK_PASS: begin
					unique case (q_head.kind)
						K_START: begin
							emit_data.frame_byte = hdr_byte('0, cfg_q, q_head.len, ck_q);
						end
						K_ERR: begin
							q_pop              = 1'b1;
							emit_data.too_long = 1'b1;
						end
						K_DATA: begin
							q_pop                = 1'b1;
							emit_data.frame_byte = q_head.data;
							emit_data.frame_last = q_head.last;
						end
						default: begin
							q_pop = 1'b1;
							emit  = 1'b0;
						end
					endcase
				end
				BK_HEADER: begin
					if (idx_q == HDR_BYTES) begin
						q_pop                = 1'b1;
						emit_data.frame_byte = q_head.data;
						emit_data.frame_last = q_head.last;
					end else begin
						emit_data.frame_byte = hdr_byte(idx_q, cfg_q, q_head.len, ck_q);
					end
				end
				default: emit = 1'b0;
			endcase
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_PASS;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Output register: load when empty or drained, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) out_data_q <= emit_data;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`ASSERT_CLK(a_back_hdr_head, (state_q != BK_HEADER) ||
		(q_nonempty && (q_head.kind == K_START)), "header without start entry")
	`ASSERT_CLK(a_back_idx_range, (idx_q <= HDR_BYTES), "header index out of range")

endmodule

@@ rtl/udp_ipv4_frame_builder.sv @@
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid / in_stall   in_data   (payload_byte, payload_len, payload_last)
// out      out_valid / out_stall out_data  (frame_byte, frame_last, too_long)
// cfg      cfg_wen               cfg_index, cfg_data
//
// A following payload byte passes the queue and output register, one per cycle while
// not stalled. A first byte gives 43 results from the back-end header sequencer.
// A 4-entry queue between front and back takes input during the header burst.
// A rejected payload gives a single error result; its dropped bytes give none.
// Reset is asynchronous and needs no clearing pass.
module udp_ipv4_frame_builder import ufb_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = 1514
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data
);

	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_nonempty;
	q_entry_t q_wdata;
	q_entry_t q_head;

	ufb_front #(
		.MaxFrameBytes(MAX_FRAME_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	ufb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wdata   (q_wdata),
		.pop     (q_pop),
		.full    (q_full),
		.nonempty(q_nonempty),
		.head    (q_head)
	);

	ufb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_nonempty(q_nonempty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ tb/tb_udp_ipv4_frame_builder.sv @@
`timescale 1ns / 1ps
module tb_udp_ipv4_frame_builder;
	import ufb_pkg::*;

	localparam int FRAME_MAX    = 1514;
	localparam int HEADER_LEN   = 42;
	localparam int ITEM_TARGET  = 480;
	localparam int QUIET_TAIL   = 80;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int REPORT_MAX   = 10;

	typedef enum logic [1:0] {
		BY_MODEL,
		NO_RESULT,
		ONE_RESULT
	} row_check_t;

	typedef enum logic [1:0] {
		REGS_KEEP,
		REGS_ONES,
		REGS_ZEROS
	} regs_action_t;

	typedef struct packed {
		regs_action_t regs;
		in_item_t     item;
		row_check_t   check;
		out_item_t    want;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_data;

	// Register copy and framing state of the predictor
	cfg_t      cfg_shadow;
	logic      pred_in_frame = 1'b0;
	logic      pred_dropping = 1'b0;
	out_item_t step_bytes[$];
	out_item_t frame_due[$];
	stim_row_t directed_rows[$];

	logic idle_on = 1'b1;
	int   stall_left = 0;
	int   cycle_count = 0;
	int   fault_count = 0;
	int   bytes_driven = 0;
	int   results_checked = 0;
	int   rejected_count = 0;
	int   reg_settings = 0;

	udp_ipv4_frame_builder #(
		.MAX_FRAME_BYTES(FRAME_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Work out the frame bytes that one accepted payload byte produces
	function automatic void frame_predict(input in_item_t it);
		logic [15:0]  ip_len;
		logic [15:0]  udp_len;
		logic [15:0]  ck;
		logic [31:0]  sum;
		logic [335:0] hdr;
		out_item_t    r;
		step_bytes.delete();
		// swallow the rest of a rejected payload
		if (pred_dropping) begin
			if (it.payload_last)
				pred_dropping = 1'b0;
			return;
		end
		if (!pred_in_frame) begin
			if (it.payload_len == '0 || HEADER_LEN + int'(it.payload_len) > FRAME_MAX) begin
				r.frame_byte = 8'h00;
				r.frame_last = 1'b0;
				r.too_long = 1'b1;
				step_bytes.push_back(r);
				pred_dropping = !it.payload_last;
				rejected_count++;
				return;
			end
			ip_len = 16'(it.payload_len) + IP_LEN_BASE;
			udp_len = 16'(it.payload_len) + UDP_LEN_BASE;
			sum = 32'({IP_VER_IHL, 8'h00}) + 32'(ip_len) + 32'(cfg_shadow.ip_ident)
				+ 32'({IP_TTL, IP_PROTO_UDP})
				+ 32'(cfg_shadow.src_ip[31:16]) + 32'(cfg_shadow.src_ip[15:0])
				+ 32'(cfg_shadow.dst_ip[31:16]) + 32'(cfg_shadow.dst_ip[15:0]);
			// fold carries twice, then invert
			sum = (sum >> 16) + (sum & 32'h0000_FFFF);
			sum = sum + (sum >> 16);
			ck = ~sum[15:0];
			hdr = {cfg_shadow.dst_mac, cfg_shadow.src_mac, ETHERTYPE_IPV4,
				IP_VER_IHL, 8'h00, ip_len, cfg_shadow.ip_ident, 16'h0000,
				IP_TTL, IP_PROTO_UDP, ck, cfg_shadow.src_ip, cfg_shadow.dst_ip,
				cfg_shadow.src_udp, cfg_shadow.dst_udp, udp_len, 16'h0000};
			for (int i = 0; i < HEADER_LEN; i++) begin
				r.frame_byte = hdr[335 - 8 * i -: 8];
				r.frame_last = 1'b0;
				r.too_long = 1'b0;
				step_bytes.push_back(r);
			end
			pred_in_frame = 1'b1;
		end
		r.frame_byte = it.payload_byte;
		r.frame_last = it.payload_last;
		r.too_long = 1'b0;
		step_bytes.push_back(r);
		if (it.payload_last)
			pred_in_frame = 1'b0;
	endfunction

	function automatic stim_row_t row(input regs_action_t regs, input logic [7:0] b,
		input logic [LEN_W-1:0] len, input logic last, input row_check_t check,
		input logic [7:0] want_byte, input logic want_last, input logic want_err);
		stim_row_t s;
		s.regs = regs;
		s.item.payload_byte = b;
		s.item.payload_len = len;
		s.item.payload_last = last;
		s.check = check;
		s.want.frame_byte = want_byte;
		s.want.frame_last = want_last;
		s.want.too_long = want_err;
		return s;
	endfunction

	function automatic void note_fault(input string what, input out_item_t want,
		input out_item_t got);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("[%0t] %s: want byte %02h last %0b too_long %0b, got byte %02h last %0b too_long %0b",
				$realtime, what, want.frame_byte, want.frame_last, want.too_long,
				got.frame_byte, got.frame_last, got.too_long);
	endfunction

	function automatic logic [47:0] skew_value(input logic [47:0] v);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return v;
		endcase
	endfunction

	task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Write every register back to back; only called while the block is idle
	task automatic program_regs(input cfg_t c);
		cfg_shadow = c;
		put_reg(CFG_SRC_MAC, c.src_mac);
		put_reg(CFG_DST_MAC, c.dst_mac);
		put_reg(CFG_SRC_IP, c.src_ip);
		put_reg(CFG_DST_IP, c.dst_ip);
		put_reg(CFG_SRC_UDP, c.src_udp);
		put_reg(CFG_DST_UDP, c.dst_udp);
		put_reg(CFG_IP_IDENT, c.ip_ident);
		cfg_wen <= 1'b0;
		reg_settings++;
	endtask

	// Drop valid and wait until every expected frame byte has come out
	task automatic settle();
		in_valid <= 1'b0;
		while (frame_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offer one payload byte, hold it until taken, then queue what it should produce
	task automatic feed_item(input in_item_t it, input row_check_t check, input out_item_t want);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_driven++;
		frame_predict(it);
		case (check)
			BY_MODEL: foreach (step_bytes[i]) frame_due.push_back(step_bytes[i]);
			ONE_RESULT: frame_due.push_back(want);
			default: ;
		endcase
	endtask

	// One random payload: mostly well formed, some cut short, some rejected
	task automatic send_payload();
		int               shape;
		int               count;
		logic [LEN_W-1:0] len;
		in_item_t         it;
		shape = $urandom_range(0, 99);
		if (shape < 65) begin
			len = LEN_W'($urandom_range(1, 12));
			count = int'(len);
		end else if (shape < 72) begin
			len = LEN_W'($urandom_range(1400, 1472));
			count = $urandom_range(1, 4);
		end else if (shape < 82) begin
			len = LEN_W'($urandom_range(1, 1472));
			count = $urandom_range(1, 16);
		end else if (shape < 92) begin
			len = ($urandom_range(0, 3) == 0) ? '0 : LEN_W'($urandom_range(1473, 2047));
			count = $urandom_range(1, 5);
		end else begin
			len = LEN_W'($urandom);
			count = $urandom_range(1, 3);
		end
		for (int k = 0; k < count; k++) begin
			it.payload_byte = 8'($urandom);
			it.payload_len = (k == 0 || $urandom_range(0, 9) != 0) ? len : LEN_W'($urandom);
			it.payload_last = (k == count - 1);
			feed_item(it, BY_MODEL, '0);
		end
	endtask

	// Check each frame byte against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (frame_due.size() == 0) begin
				note_fault("unexpected frame byte", '0, out_data);
			end else begin
				want = frame_due.pop_front();
				if (out_data.frame_byte !== want.frame_byte
					|| out_data.frame_last !== want.frame_last
					|| out_data.too_long !== want.too_long)
					note_fault("frame byte mismatch", want, out_data);
			end
		end
	end

	// Stall the output in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d frame bytes still due",
				cycle_count, frame_due.size());
			$display("udp_ipv4_frame_builder regression: fail");
			$finish;
		end
	end

	initial begin
		cfg_t pick;
		logic quiet;
		cfg_shadow = '0;
		cfg_shadow.dst_mac = '1;

		// reset defaults, header extremes and the length corner cases
		directed_rows.push_back(row(REGS_KEEP, 8'h00, 11'd1, 1'b1, BY_MODEL, 8'h00, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'hFF, 11'd3, 1'b0, BY_MODEL, 8'h00, 1'b0, 1'b0));
		// length is taken from the first byte only
		directed_rows.push_back(row(REGS_KEEP, 8'h5A, 11'd2047, 1'b0, ONE_RESULT, 8'h5A, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'hA5, 11'd0, 1'b1, ONE_RESULT, 8'hA5, 1'b1, 1'b0));
		// zero length on a single byte: error only, nothing to drop
		directed_rows.push_back(row(REGS_KEEP, 8'h11, 11'd0, 1'b1, ONE_RESULT, 8'h00, 1'b0, 1'b1));
		// just over the limit, then drop through the last byte
		directed_rows.push_back(row(REGS_KEEP, 8'h22, 11'd1473, 1'b0, ONE_RESULT, 8'h00, 1'b0, 1'b1));
		directed_rows.push_back(row(REGS_KEEP, 8'h33, 11'd5, 1'b0, NO_RESULT, 8'h00, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'h44, 11'd1473, 1'b1, NO_RESULT, 8'h00, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'h80, 11'd2047, 1'b1, ONE_RESULT, 8'h00, 1'b0, 1'b1));
		// largest accepted length, ended early
		directed_rows.push_back(row(REGS_KEEP, 8'h01, 11'd1472, 1'b0, BY_MODEL, 8'h00, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'h7F, 11'd1, 1'b1, ONE_RESULT, 8'h7F, 1'b1, 1'b0));
		// more bytes than declared
		directed_rows.push_back(row(REGS_KEEP, 8'hC3, 11'd1, 1'b0, BY_MODEL, 8'h00, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'h3C, 11'd1, 1'b0, ONE_RESULT, 8'h3C, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'hFF, 11'd1, 1'b1, ONE_RESULT, 8'hFF, 1'b1, 1'b0));
		// zero length with bytes to drop
		directed_rows.push_back(row(REGS_KEEP, 8'h00, 11'd0, 1'b0, ONE_RESULT, 8'h00, 1'b0, 1'b1));
		directed_rows.push_back(row(REGS_KEEP, 8'hFF, 11'd2047, 1'b0, NO_RESULT, 8'h00, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'h00, 11'd0, 1'b1, NO_RESULT, 8'h00, 1'b0, 1'b0));
		// all-ones and all-zeros register settings
		directed_rows.push_back(row(REGS_ONES, 8'hFF, 11'd2, 1'b0, BY_MODEL, 8'h00, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'h00, 11'd2, 1'b1, ONE_RESULT, 8'h00, 1'b1, 1'b0));
		directed_rows.push_back(row(REGS_ZEROS, 8'h55, 11'd1024, 1'b1, BY_MODEL, 8'h00, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'hAA, 11'd1471, 1'b1, BY_MODEL, 8'h00, 1'b0, 1'b0));
		directed_rows.push_back(row(REGS_KEEP, 8'h69, 11'd1472, 1'b1, BY_MODEL, 8'h00, 1'b0, 1'b0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (directed_rows[k]) begin
			if (directed_rows[k].regs != REGS_KEEP) begin
				settle();
				pick = (directed_rows[k].regs == REGS_ONES) ? '1 : '0;
				program_regs(pick);
			end
			feed_item(directed_rows[k].item, directed_rows[k].check, directed_rows[k].want);
		end

		// random phases, each with a fresh register setting
		while (bytes_driven < ITEM_TARGET) begin
			settle();
			quiet = ($urandom_range(0, 3) == 0);
			idle_on = !quiet && (bytes_driven < ITEM_TARGET - QUIET_TAIL);
			pick.src_mac = skew_value(48'({$urandom, $urandom}));
			pick.dst_mac = skew_value(48'({$urandom, $urandom}));
			pick.src_ip = 32'(skew_value(48'($urandom)));
			pick.dst_ip = 32'(skew_value(48'($urandom)));
			pick.src_udp = 16'(skew_value(48'($urandom)));
			pick.dst_udp = 16'(skew_value(48'($urandom)));
			pick.ip_ident = 16'(skew_value(48'($urandom)));
			program_regs(pick);
			repeat ($urandom_range(3, 8)) begin
				// no idling in the closing stretch
				if (bytes_driven >= ITEM_TARGET - QUIET_TAIL)
					idle_on = 1'b0;
				if (bytes_driven < ITEM_TARGET)
					send_payload();
			end
		end

		idle_on = 1'b0;
		settle();
		$display("drove %0d payload bytes under %0d register settings", bytes_driven, reg_settings);
		$display("checked %0d frame bytes, %0d payloads rejected, %0d mismatches",
			results_checked, rejected_count, fault_count);
		if (fault_count == 0) begin
			$display("udp_ipv4_frame_builder regression: pass");
		end else begin
			$display("udp_ipv4_frame_builder regression: fail");
		end
		$finish;
	end

endmodule
